[hw/rtl/pgf_pkg.sv]
`default_nettype none

package pgf_pkg;

   // configuration register map, index is the word address
   typedef enum logic {
      REG_GRAVITY  = 1'b0,
      REG_MIN_DIST = 1'b1
   } reg_index_type;

   localparam logic [31:0] GRAVITY_RESET  = 32'd1230829800;
   localparam logic [31:0] MIN_DIST_RESET = 32'd32768;
   localparam logic [63:0] MIN_DIST_SQ_RESET = 64'(MIN_DIST_RESET) * 64'(MIN_DIST_RESET);

   // multiplier bits consumed per pipeline stage
   localparam int MUL_CHUNK = 8;

   // quotient bits below the saturation point of a Q32.16 component
   localparam int QUO_BITS   = 47;
   localparam int FORCE_BITS = 48;

   localparam logic [FORCE_BITS-1:0] FORCE_POS_MAX = {1'b0, {(FORCE_BITS-1){1'b1}}};
   localparam logic [FORCE_BITS-1:0] FORCE_NEG_MAG = {1'b1, {(FORCE_BITS-1){1'b0}}};

   typedef struct packed {
      logic [31:0] gravity;
      logic [63:0] min_dist_sq;
   } cfg_type;

endpackage

`default_nettype wire

[hw/rtl/pgf_delay.sv]
`default_nettype none

module pgf_delay #(
   parameter int WIDTH = 1,
   parameter int DEPTH = 1
) (
   input  logic             clock,
   input  logic             reset,
   input  logic [WIDTH-1:0] d,
   output logic [WIDTH-1:0] q
);

   logic [WIDTH-1:0] tap_ff [DEPTH];

   always_ff @(posedge clock) begin
      if (reset) begin
         for (int i = 0; i < DEPTH; i++) begin
            tap_ff[i] <= '0;
         end
      end else begin
         tap_ff[0] <= d;
         for (int i = 1; i < DEPTH; i++) begin
            tap_ff[i] <= tap_ff[i-1];
         end
      end
   end

   assign q = tap_ff[DEPTH-1];

endmodule

`default_nettype wire

[hw/rtl/pgf_mul.sv]
`default_nettype none

// product a*b, one chunk of b per stage
module pgf_mul #(
   parameter int AW = 32,
   parameter int BW = 32
) (
   input  logic             clock,
   input  logic [AW-1:0]    a,
   input  logic [BW-1:0]    b,
   output logic [AW+BW-1:0] p
);

   localparam int CH  = pgf_pkg::MUL_CHUNK;
   localparam int NS  = (BW + CH - 1) / CH;
   localparam int PW  = AW + BW;
   localparam int BPW = NS * CH;
   localparam int QW  = AW + CH;

   logic [PW-1:0]  acc_ff [NS];
   logic [AW-1:0]  a_ff   [NS];
   logic [BPW-1:0] b_ff   [NS];
   logic [BPW-1:0] b_pad;

   assign b_pad = BPW'(b);

   for (genvar j = 0; j < NS; j++) begin : g_stage
      if (j == 0) begin : g_first
         always_ff @(posedge clock) begin
            acc_ff[0] <= PW'(QW'(a) * QW'(b_pad[CH-1:0]));
            a_ff[0]   <= a;
            b_ff[0]   <= b_pad;
         end
      end else begin : g_next
         logic [QW-1:0] part_in;
         assign part_in = QW'(a_ff[j-1]) * QW'(b_ff[j-1][CH*j +: CH]);
         always_ff @(posedge clock) begin
            acc_ff[j] <= acc_ff[j-1] + (PW'(part_in) << (CH * j));
            a_ff[j]   <= a_ff[j-1];
            b_ff[j]   <= b_ff[j-1];
         end
      end
   end

   assign p = acc_ff[NS-1];

endmodule

`default_nettype wire

[hw/rtl/pgf_sqrt.sv]
`default_nettype none

// floor square root, one result bit per stage
module pgf_sqrt #(
   parameter int SW = 66
) (
   input  logic                  clock,
   input  logic [SW-1:0]         s,
   output logic [(SW+1)/2-1:0]   root
);

   localparam int RW   = (SW + 1) / 2;
   localparam int PADW = 2 * RW;
   localparam int TW   = RW + 3;

   logic [TW-1:0]   rem_ff  [RW];
   logic [RW-1:0]   root_ff [RW];
   logic [PADW-1:0] rad_ff  [RW];

   for (genvar i = 0; i < RW; i++) begin : g_stage
      logic [TW-1:0]   rem_p;
      logic [RW-1:0]   root_p;
      logic [PADW-1:0] rad_p;
      logic [TW-1:0]   cur;
      logic [TW-1:0]   trial;
      logic            ge;

      if (i == 0) begin : g_first
         assign rem_p  = '0;
         assign root_p = '0;
         assign rad_p  = PADW'(s);
      end else begin : g_next
         assign rem_p  = rem_ff[i-1];
         assign root_p = root_ff[i-1];
         assign rad_p  = rad_ff[i-1];
      end

      // bring down the next two radicand bits, try root*4+1
      assign cur   = {rem_p[TW-3:0], rad_p[PADW-1 -: 2]};
      assign trial = TW'({root_p, 2'b01});
      assign ge    = cur >= trial;

      always_ff @(posedge clock) begin
         rem_ff[i]  <= ge ? cur - trial : cur;
         root_ff[i] <= {root_p[RW-2:0], ge};
         rad_ff[i]  <= rad_p << 2;
      end
   end

   assign root = root_ff[RW-1];

endmodule

`default_nettype wire

[hw/rtl/pgf_div.sv]
`default_nettype none

// restoring divider: overflow check, then one quotient bit per stage
module pgf_div #(
   parameter int NW = 129,
   parameter int DW = 115
) (
   input  logic                          clock,
   input  logic [NW-1:0]                 num,
   input  logic [DW-1:0]                 den,
   output logic [pgf_pkg::QUO_BITS-1:0]  quo,
   output logic                          ovf
);

   localparam int QB = pgf_pkg::QUO_BITS;
   localparam int W  = DW + QB + 1;

   logic [W-1:0]  rem_ff [QB+1];
   logic [DW-1:0] den_ff [QB+1];
   logic [QB-1:0] quo_ff [QB+1];
   logic          ovf_ff [QB+1];

   always_ff @(posedge clock) begin
      rem_ff[0] <= W'(num);
      den_ff[0] <= den;
      quo_ff[0] <= '0;
      // quotient at or above the saturation point
      ovf_ff[0] <= W'(num) >= (W'(den) << QB);
   end

   for (genvar s = 1; s <= QB; s++) begin : g_stage
      localparam int SH = QB - s;
      logic [W-1:0]  shifted;
      logic          ge;
      logic [QB-1:0] quo_in;

      assign shifted = W'(den_ff[s-1]) << SH;
      assign ge      = rem_ff[s-1] >= shifted;
      assign quo_in  = quo_ff[s-1] | (QB'(ge) << SH);

      always_ff @(posedge clock) begin
         rem_ff[s] <= ge ? rem_ff[s-1] - shifted : rem_ff[s-1];
         den_ff[s] <= den_ff[s-1];
         quo_ff[s] <= quo_in;
         ovf_ff[s] <= ovf_ff[s-1];
      end
   end

   assign quo = quo_ff[QB];
   assign ovf = ovf_ff[QB];

endmodule

`default_nettype wire

[hw/rtl/pgf_csr.sv]
`default_nettype none

module pgf_csr (
   input  logic                clock,
   input  logic                reset,
   input  logic                psel,
   input  logic                penable,
   input  logic                pwrite,
   input  logic [2:0]          paddr,
   input  logic [31:0]         pwdata,
   output logic [31:0]         prdata,
   output logic                pready,
   output pgf_pkg::cfg_type    cfg
);

   logic [31:0] gravity_ff;
   logic [31:0] min_dist_ff;
   logic [63:0] min_dist_sq_ff;
   logic        wr_in;
   pgf_pkg::reg_index_type idx;

   assign idx   = pgf_pkg::reg_index_type'(paddr[2]);
   assign wr_in = psel && penable && pwrite;

   always_ff @(posedge clock) begin
      if (reset) begin
         gravity_ff     <= pgf_pkg::GRAVITY_RESET;
         min_dist_ff    <= pgf_pkg::MIN_DIST_RESET;
         min_dist_sq_ff <= pgf_pkg::MIN_DIST_SQ_RESET;
      end else begin
         if (wr_in && idx == pgf_pkg::REG_GRAVITY) begin
            gravity_ff <= pwdata;
         end
         if (wr_in && idx == pgf_pkg::REG_MIN_DIST) begin
            min_dist_ff <= pwdata;
         end
         min_dist_sq_ff <= 64'(min_dist_ff) * 64'(min_dist_ff);
      end
   end

   always_comb begin
      unique case (idx)
         pgf_pkg::REG_GRAVITY:  prdata = gravity_ff;
         pgf_pkg::REG_MIN_DIST: prdata = min_dist_ff;
         default:               prdata = '0;
      endcase
   end

   assign pready          = 1'b1;
   assign cfg.gravity     = gravity_ff;
   assign cfg.min_dist_sq = min_dist_sq_ff;

endmodule

`default_nettype wire

[hw/rtl/pairwise_gravity_force.sv]
// throughput: one request per cycle, busy is never raised; the receiver cannot stall
// reset: clears all valid bits and the delay lines and loads the register defaults; other payload is not cleared
`default_nettype none

module pairwise_gravity_force #(
   parameter int POSITION_BITS = 32
) (
   input  logic                            clock,
   input  logic                            reset,
   input  logic                            start,
   output logic                            busy,
   input  logic signed [POSITION_BITS-1:0] req_pos_a_x,
   input  logic signed [POSITION_BITS-1:0] req_pos_a_y,
   input  logic signed [POSITION_BITS-1:0] req_pos_a_z,
   input  logic signed [POSITION_BITS-1:0] req_pos_b_x,
   input  logic signed [POSITION_BITS-1:0] req_pos_b_y,
   input  logic signed [POSITION_BITS-1:0] req_pos_b_z,
   input  logic [31:0]                     req_mass_a,
   input  logic [31:0]                     req_mass_b,
   input  logic                            req_also_to_other,
   output logic                            rsp_valid,
   output logic signed [47:0]              rsp_force_x,
   output logic signed [47:0]              rsp_force_y,
   output logic signed [47:0]              rsp_force_z,
   output logic                            rsp_applied,
   output logic                            rsp_mirror_to_other,
   input  logic                            psel,
   input  logic                            penable,
   input  logic                            pwrite,
   input  logic [2:0]                      paddr,
   input  logic [31:0]                     pwdata,
   output logic [31:0]                     prdata,
   output logic                            pready
);

   localparam int P      = POSITION_BITS;
   localparam int CH     = pgf_pkg::MUL_CHUNK;
   localparam int FB     = pgf_pkg::FORCE_BITS;
   localparam int QB     = pgf_pkg::QUO_BITS;
   localparam int MW     = P + 1;
   localparam int SW     = 2 * MW;
   localparam int RW     = (SW + 1) / 2;
   localparam int NM     = (MW + CH - 1) / CH;
   localparam int NR     = (RW + CH - 1) / CH;
   localparam int NMASS  = (32 + CH - 1) / CH;
   localparam int KW     = 96;
   localparam int DENW   = SW + RW + 16;
   localparam int NUMW   = KW + MW;
   localparam int CMPW   = (SW > 64) ? SW : 64;
   localparam int T_S    = NM + 2;
   localparam int T_D    = T_S + RW + NR;
   localparam int T_K    = 2 * NMASS;
   localparam int T_Q    = T_D + NM + QB + 1;

   pgf_pkg::cfg_type cfg;

   pgf_csr u_csr (
      .clock   (clock),
      .reset   (reset),
      .psel    (psel),
      .penable (penable),
      .pwrite  (pwrite),
      .paddr   (paddr),
      .pwdata  (pwdata),
      .prdata  (prdata),
      .pready  (pready),
      .cfg     (cfg)
   );

   assign busy = 1'b0;

   // capture stage
   logic          valid0_ff;
   logic          also_ff;
   logic [P-1:0]  pos_a_ff [3];
   logic [P-1:0]  pos_b_ff [3];
   logic [31:0]   mass_a_ff;
   logic [31:0]   mass_b_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         valid0_ff <= 1'b0;
      end else begin
         valid0_ff <= start;
      end
   end

   always_ff @(posedge clock) begin
      if (start) begin
         pos_a_ff[0] <= req_pos_a_x;
         pos_a_ff[1] <= req_pos_a_y;
         pos_a_ff[2] <= req_pos_a_z;
         pos_b_ff[0] <= req_pos_b_x;
         pos_b_ff[1] <= req_pos_b_y;
         pos_b_ff[2] <= req_pos_b_z;
         mass_a_ff   <= req_mass_a;
         mass_b_ff   <= req_mass_b;
         also_ff     <= req_also_to_other;
      end
   end

   // axis differences b - a, kept as sign and magnitude
   logic [MW-1:0] diff_in [3];
   logic [MW-1:0] mag_in  [3];
   logic [MW-1:0] mag_ff  [3];
   logic [2:0]    neg_ff;

   always_comb begin
      for (int i = 0; i < 3; i++) begin
         diff_in[i] = {pos_b_ff[i][P-1], pos_b_ff[i]} - {pos_a_ff[i][P-1], pos_a_ff[i]};
         mag_in[i]  = diff_in[i][MW-1] ? MW'(-diff_in[i]) : diff_in[i];
      end
   end

   always_ff @(posedge clock) begin
      for (int i = 0; i < 3; i++) begin
         mag_ff[i] <= mag_in[i];
         neg_ff[i] <= diff_in[i][MW-1];
      end
   end

   // squared distance
   logic [SW-1:0] sq [3];

   for (genvar i = 0; i < 3; i++) begin : g_sq
      pgf_mul #(.AW(MW), .BW(MW)) u_sq (
         .clock (clock),
         .a     (mag_ff[i]),
         .b     (mag_ff[i]),
         .p     (sq[i])
      );
   end

   logic [SW-1:0] dist_sq_ff;
   logic          close_in;

   always_ff @(posedge clock) begin
      dist_sq_ff <= sq[0] + sq[1] + sq[2];
   end

   assign close_in = CMPW'(dist_sq_ff) <= CMPW'(cfg.min_dist_sq);

   // denominator 2^16 * s * floor(sqrt(s))
   logic [RW-1:0]      root;
   logic [SW-1:0]      dist_sq_dly;
   logic [SW+RW-1:0]   den_raw;
   logic [DENW-1:0]    den_dly;

   pgf_sqrt #(.SW(SW)) u_sqrt (
      .clock (clock),
      .s     (dist_sq_ff),
      .root  (root)
   );

   pgf_delay #(.WIDTH(SW), .DEPTH(RW)) u_dist_sq_dly (
      .clock (clock),
      .reset (reset),
      .d     (dist_sq_ff),
      .q     (dist_sq_dly)
   );

   pgf_mul #(.AW(SW), .BW(RW)) u_den_mul (
      .clock (clock),
      .a     (dist_sq_dly),
      .b     (root),
      .p     (den_raw)
   );

   pgf_delay #(.WIDTH(DENW), .DEPTH(NM)) u_den_dly (
      .clock (clock),
      .reset (reset),
      .d     ({den_raw, 16'b0}),
      .q     (den_dly)
   );

   // numerator G * ma * mb * |d|
   logic [63:0]   k1;
   logic [31:0]   mass_b_dly;
   logic [KW-1:0] k;
   logic [KW-1:0] k_dly;

   pgf_mul #(.AW(32), .BW(32)) u_k1_mul (
      .clock (clock),
      .a     (cfg.gravity),
      .b     (mass_a_ff),
      .p     (k1)
   );

   pgf_delay #(.WIDTH(32), .DEPTH(NMASS)) u_mass_b_dly (
      .clock (clock),
      .reset (reset),
      .d     (mass_b_ff),
      .q     (mass_b_dly)
   );

   pgf_mul #(.AW(64), .BW(32)) u_k_mul (
      .clock (clock),
      .a     (k1),
      .b     (mass_b_dly),
      .p     (k)
   );

   pgf_delay #(.WIDTH(KW), .DEPTH(T_D - T_K)) u_k_dly (
      .clock (clock),
      .reset (reset),
      .d     (k),
      .q     (k_dly)
   );

   logic [QB-1:0] quo [3];
   logic [2:0]    ovf;

   for (genvar i = 0; i < 3; i++) begin : g_axis
      logic [MW-1:0]   mag_dly;
      logic [NUMW-1:0] num;

      pgf_delay #(.WIDTH(MW), .DEPTH(T_D - 1)) u_mag_dly (
         .clock (clock),
         .reset (reset),
         .d     (mag_ff[i]),
         .q     (mag_dly)
      );

      pgf_mul #(.AW(KW), .BW(MW)) u_num_mul (
         .clock (clock),
         .a     (k_dly),
         .b     (mag_dly),
         .p     (num)
      );

      pgf_div #(.NW(NUMW), .DW(DENW)) u_div (
         .clock (clock),
         .num   (num),
         .den   (den_dly),
         .quo   (quo[i]),
         .ovf   (ovf[i])
      );
   end

   // side information riding along with the data
   logic [1:0] ctl_dly;
   logic [2:0] neg_dly;
   logic       close_dly;

   pgf_delay #(.WIDTH(2), .DEPTH(T_Q)) u_ctl_dly (
      .clock (clock),
      .reset (reset),
      .d     ({valid0_ff, also_ff}),
      .q     (ctl_dly)
   );

   pgf_delay #(.WIDTH(3), .DEPTH(T_Q - 1)) u_neg_dly (
      .clock (clock),
      .reset (reset),
      .d     (neg_ff),
      .q     (neg_dly)
   );

   pgf_delay #(.WIDTH(1), .DEPTH(T_Q - T_S)) u_close_dly (
      .clock (clock),
      .reset (reset),
      .d     (close_in),
      .q     (close_dly)
   );

   // saturate, apply sign, zero the force when too close and register the result
   logic [FB-1:0] force_in [3];
   logic [FB-1:0] force_ff [3];
   logic          valid_ff;
   logic          applied_ff;
   logic          mirror_ff;

   always_comb begin
      for (int i = 0; i < 3; i++) begin
         if (close_dly) begin
            force_in[i] = '0;
         end else if (neg_dly[i]) begin
            force_in[i] = ovf[i] ? pgf_pkg::FORCE_NEG_MAG : FB'(-FB'(quo[i]));
         end else begin
            force_in[i] = ovf[i] ? pgf_pkg::FORCE_POS_MAX : FB'(quo[i]);
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else begin
         valid_ff <= ctl_dly[1];
      end
   end

   always_ff @(posedge clock) begin
      for (int i = 0; i < 3; i++) begin
         force_ff[i] <= force_in[i];
      end
      applied_ff <= !close_dly;
      mirror_ff  <= !close_dly && ctl_dly[0];
   end

   assign rsp_valid           = valid_ff;
   assign rsp_force_x         = force_ff[0];
   assign rsp_force_y         = force_ff[1];
   assign rsp_force_z         = force_ff[2];
   assign rsp_applied         = applied_ff;
   assign rsp_mirror_to_other = mirror_ff;

endmodule

`default_nettype wire

[test/pairwise_gravity_force_tb.sv]
`default_nettype none

module pairwise_gravity_force_tb;
   timeunit 1ns;
   timeprecision 1ps;

   localparam int LATENCY     = 99;
   localparam int CYCLE_LIMIT = 600000;
   localparam int N_DIRECTED  = 11;

   typedef struct {
      logic signed [31:0] ax, ay, az, bx, by, bz;
      logic [31:0]        mass_a, mass_b;
      logic               also;
   } body_pair_type;

   typedef struct {
      logic signed [47:0] fx, fy, fz;
      logic               applied, mirror;
   } force_type;

   logic clock = 1'b0;
   logic reset = 1'b1;
   logic start = 1'b0;
   logic busy;
   logic signed [31:0] req_pos_a_x = '0, req_pos_a_y = '0, req_pos_a_z = '0;
   logic signed [31:0] req_pos_b_x = '0, req_pos_b_y = '0, req_pos_b_z = '0;
   logic [31:0] req_mass_a = '0, req_mass_b = '0;
   logic req_also_to_other = 1'b0;
   logic rsp_valid;
   logic signed [47:0] rsp_force_x, rsp_force_y, rsp_force_z;
   logic rsp_applied, rsp_mirror_to_other;
   logic psel = 1'b0, penable = 1'b0, pwrite = 1'b0;
   logic [2:0] paddr = '0;
   logic [31:0] pwdata = '0;
   logic [31:0] prdata;
   logic pready;

   pairwise_gravity_force DUT (.*);

   always #10 clock = ~clock;

   // local copy of the register file
   logic [31:0] g_const  = pgf_pkg::GRAVITY_RESET;
   logic [31:0] min_dist = pgf_pkg::MIN_DIST_RESET;

   force_type pending_forces[$];
   int  errors = 0;
   int  cycles = 0;
   int  idle_pct = 0;

   function automatic force_type gravity_force(body_pair_type p);
      force_type f;
      logic signed [33:0] d[3];
      logic [255:0] mag[3];
      logic [255:0] s, lim, t, root, den, k, num, q;
      logic [47:0] comp[3];
      d[0] = 34'(p.bx) - 34'(p.ax);
      d[1] = 34'(p.by) - 34'(p.ay);
      d[2] = 34'(p.bz) - 34'(p.az);
      s = '0;
      for (int i = 0; i < 3; i++) begin
         mag[i] = d[i] < 0 ? 256'(-d[i]) : 256'(d[i]);
         s = s + mag[i] * mag[i];
      end
      lim = 256'(min_dist);
      lim = lim * lim;
      f = '{fx: '0, fy: '0, fz: '0, applied: 1'b0, mirror: 1'b0};
      if (s <= lim) return f;
      root = '0;
      for (int b = 51; b >= 0; b--) begin
         t = root | (256'(1) << b);
         if (t * t <= s) root = t;
      end
      den = s * (root << 16);
      k = 256'(g_const);
      k = k * 256'(p.mass_a);
      k = k * 256'(p.mass_b);
      for (int i = 0; i < 3; i++) begin
         num = k * mag[i];
         q = num / den;
         if (d[i] < 0) begin
            if (q > 256'(pgf_pkg::FORCE_NEG_MAG)) q = 256'(pgf_pkg::FORCE_NEG_MAG);
            comp[i] = -q[47:0];
         end else begin
            if (q > 256'(pgf_pkg::FORCE_POS_MAX)) q = 256'(pgf_pkg::FORCE_POS_MAX);
            comp[i] = q[47:0];
         end
      end
      f.fx = comp[0];
      f.fy = comp[1];
      f.fz = comp[2];
      f.applied = 1'b1;
      f.mirror = p.also;
      return f;
   endfunction

   task automatic csr_write(pgf_pkg::reg_index_type idx, logic [31:0] value);
      @(negedge clock);
      psel <= 1'b1;
      penable <= 1'b0;
      pwrite <= 1'b1;
      paddr <= {idx, 2'b00};
      pwdata <= value;
      @(negedge clock);
      penable <= 1'b1;
      do @(posedge clock); while (!pready);
      @(negedge clock);
      psel <= 1'b0;
      penable <= 1'b0;
      pwrite <= 1'b0;
      if (idx == pgf_pkg::REG_GRAVITY) g_const = value;
      else min_dist = value;
   endtask

   task automatic wait_drained();
      while (pending_forces.size() != 0) @(posedge clock);
      repeat (LATENCY + 10) @(posedge clock);
   endtask

   // drive one request; the expectation is queued once it is taken
   task automatic send_pair(body_pair_type p, bit known, force_type known_force);
      while ($urandom_range(99) < idle_pct) begin
         start <= 1'b0;
         @(negedge clock);
      end
      start <= 1'b1;
      req_pos_a_x <= p.ax;
      req_pos_a_y <= p.ay;
      req_pos_a_z <= p.az;
      req_pos_b_x <= p.bx;
      req_pos_b_y <= p.by;
      req_pos_b_z <= p.bz;
      req_mass_a <= p.mass_a;
      req_mass_b <= p.mass_b;
      req_also_to_other <= p.also;
      do @(posedge clock); while (busy);
      pending_forces.push_back(known ? known_force : gravity_force(p));
      @(negedge clock);
   endtask

   function automatic logic [31:0] rand_span();
      logic [31:0] v;
      v = $urandom();
      return v >> $urandom_range(31);
   endfunction

   function automatic body_pair_type random_pair();
      body_pair_type p;
      p.ax = $urandom();
      p.ay = $urandom();
      p.az = $urandom();
      if ($urandom_range(9) < 2) begin
         p.bx = $urandom();
         p.by = $urandom();
         p.bz = $urandom();
      end else begin
         // nearby bodies give forces in range
         p.bx = p.ax + ($urandom_range(1) ? rand_span() : -rand_span());
         p.by = p.ay + ($urandom_range(1) ? rand_span() : -rand_span());
         p.bz = p.az + ($urandom_range(1) ? rand_span() : -rand_span());
      end
      p.mass_a = $urandom_range(3) == 0 ? $urandom() : rand_span();
      p.mass_b = $urandom_range(3) == 0 ? $urandom() : rand_span();
      p.also = 1'($urandom_range(1));
      return p;
   endfunction

   // result checker
   always @(posedge clock) begin
      force_type want;
      if (!reset && rsp_valid) begin
         if (pending_forces.size() == 0) begin
            $display("%0t: unexpected result fx=%h fy=%h fz=%h", $time,
                     rsp_force_x, rsp_force_y, rsp_force_z);
            errors++;
         end else begin
            want = pending_forces.pop_front();
            if (rsp_force_x !== want.fx || rsp_force_y !== want.fy ||
                rsp_force_z !== want.fz || rsp_applied !== want.applied ||
                rsp_mirror_to_other !== want.mirror) begin
               $display("%0t: mismatch expected %h %h %h applied=%b mirror=%b", $time,
                        want.fx, want.fy, want.fz, want.applied, want.mirror);
               $display("%0t:          actual   %h %h %h applied=%b mirror=%b", $time,
                        rsp_force_x, rsp_force_y, rsp_force_z, rsp_applied,
                        rsp_mirror_to_other);
               errors++;
            end
         end
      end
   end

   always @(posedge clock) begin
      cycles++;
      if (cycles > CYCLE_LIMIT) begin
         $display("Verification failed");
         $finish;
      end
   end

   body_pair_type dir_pair[N_DIRECTED];
   bit            dir_known[N_DIRECTED];
   force_type     dir_force[N_DIRECTED];

   initial begin
      force_type none;
      none = '{fx: '0, fy: '0, fz: '0, applied: 1'b0, mirror: 1'b0};
      // coincident bodies, too close
      dir_pair[0]  = '{0, 0, 0, 0, 0, 0, 32'hFFFF_FFFF, 32'hFFFF_FFFF, 1};
      // coincident at the positive corner, too close
      dir_pair[1]  = '{32'h7FFF_FFFF, 32'h7FFF_FFFF, 32'h7FFF_FFFF,
                       32'h7FFF_FFFF, 32'h7FFF_FFFF, 32'h7FFF_FFFF, 5, 7, 1};
      // zero mass still counts as applied
      dir_pair[2]  = '{0, 0, 0, 32'h0001_0000, 0, 0, 0, 32'hFFFF_FFFF, 1};
      // opposite corners, both directions
      dir_pair[3]  = '{32'h8000_0000, 32'h8000_0000, 32'h8000_0000,
                       32'h7FFF_FFFF, 32'h7FFF_FFFF, 32'h7FFF_FFFF,
                       32'hFFFF_FFFF, 32'hFFFF_FFFF, 1};
      dir_pair[4]  = '{32'h7FFF_FFFF, 32'h7FFF_FFFF, 32'h7FFF_FFFF,
                       32'h8000_0000, 32'h8000_0000, 32'h8000_0000,
                       32'hFFFF_FFFF, 32'hFFFF_FFFF, 0};
      // just beyond the minimum distance, saturates both ways
      dir_pair[5]  = '{0, 0, 0, 32'h0000_8001, 0, 0, 32'hFFFF_FFFF, 32'hFFFF_FFFF, 1};
      dir_pair[6]  = '{0, 0, 0, -32'sh0000_8001, 0, 0, 32'hFFFF_FFFF, 32'hFFFF_FFFF, 1};
      // exactly at the minimum distance, too close
      dir_pair[7]  = '{0, 0, 0, 0, 32'h0000_8000, 0, 32'hFFFF_FFFF, 32'hFFFF_FFFF, 1};
      // no offset along x
      dir_pair[8]  = '{32'h1234_5678, 32'h0001_0000, 0,
                       32'h1234_5678, -32'sh0003_0000, 32'h0004_0000, 1000000, 3000000, 0};
      dir_pair[9]  = '{-32'sh0010_0000, 0, 32'h0002_0000,
                       32'h0010_0000, 32'h0001_0000, 0, 32'hFFFF_FFFF, 1, 1};
      dir_pair[10] = '{32'h0100_0000, 32'h0100_0000, 32'h0100_0000,
                       0, 0, 0, 32'h8000_0000, 32'h8000_0000, 0};
      dir_known  = '{1, 1, 1, 0, 0, 0, 0, 1, 0, 0, 0};
      foreach (dir_force[i]) dir_force[i] = none;
      dir_force[2] = '{fx: '0, fy: '0, fz: '0, applied: 1'b1, mirror: 1'b1};

      repeat (4) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;

      for (int i = 0; i < N_DIRECTED; i++)
         send_pair(dir_pair[i], dir_known[i], dir_force[i]);
      start <= 1'b0;

      for (int ph = 0; ph < 6; ph++) begin
         wait_drained();
         unique case (ph)
            0: begin
               csr_write(pgf_pkg::REG_GRAVITY, 32'hFFFF_FFFF);
               csr_write(pgf_pkg::REG_MIN_DIST, 32'h0);
            end
            1: begin
               csr_write(pgf_pkg::REG_GRAVITY, 32'h0);
               csr_write(pgf_pkg::REG_MIN_DIST, 32'hFFFF_FFFF);
            end
            3: begin
               csr_write(pgf_pkg::REG_GRAVITY, pgf_pkg::GRAVITY_RESET);
               csr_write(pgf_pkg::REG_MIN_DIST, pgf_pkg::MIN_DIST_RESET);
            end
            default: begin
               csr_write(pgf_pkg::REG_GRAVITY, $urandom());
               csr_write(pgf_pkg::REG_MIN_DIST, rand_span() >> 8);
            end
         endcase
         idle_pct = ph % 3 == 0 ? 6 : (ph % 3 == 1 ? 73 : 0);
         for (int n = 0; n < 158; n++)
            send_pair(random_pair(), 1'b0, none);
         start <= 1'b0;
      end

      wait_drained();
      if (errors == 0)
         $display("Verification passed");
      else
         $display("Verification failed");
      $finish;
   end

endmodule

`default_nettype wire
